// ===== sv/scs_pkg.sv =====
// Shared types and constants for the scissor clip stack.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps

package scs_pkg;

    localparam int unsigned STACK_DEPTH_DEF = 16;

    typedef enum logic [1:0] {
        ACT_SET   = 2'd0,
        ACT_PUSH  = 2'd1,
        ACT_POP   = 2'd2,
        ACT_FRAME = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_UNDERFLOW = 2'd1,
        STS_OVERFLOW  = 2'd2
    } t_status;

    // Where the new current rectangle comes from at commit
    typedef enum logic [2:0] {
        SRC_SET,
        SRC_PUSH,
        SRC_POP,
        SRC_CLEAR,
        SRC_NONE
    } t_src;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_EXEC,
        FSM_FINISH
    } t_fsm;

    typedef struct packed {
        logic               en;
        logic signed [15:0] left;
        logic signed [15:0] bottom;
        logic        [14:0] width;
        logic        [14:0] height;
    } t_rect;

    typedef struct packed {
        logic    load;
        logic    push;
        logic    pop;
        logic    commit;
        t_src    src;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        t_action action;
        logic    full;
        logic    empty;
    } t_dp_stat;

endpackage

// ===== sv/scs_ctrl.sv =====
// Controller state machine for the scissor clip stack.
// Depends on scs_pkg; drives the datapath through t_dp_cmd.
`timescale 1ns / 1ps

module scs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    input  scs_pkg::t_dp_stat i_stat,
    output scs_pkg::t_dp_cmd  o_cmd
);

    scs_pkg::t_fsm    r_state, n_state;
    scs_pkg::t_src    r_src, n_src;
    scs_pkg::t_status r_status, n_status;
    logic             r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= scs_pkg::FSM_IDLE;
            r_src       <= scs_pkg::SRC_NONE;
            r_status    <= scs_pkg::STS_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_src       <= n_src;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_src       = r_src;
        n_status    = r_status;
        o_cmd       = '0;
        o_cmd.src   = r_src;
        o_cmd.status = r_status;
        o_ready     = 1'b0;
        n_out_valid = r_out_valid && !i_ready;

        unique case (r_state)
            scs_pkg::FSM_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = scs_pkg::FSM_EXEC;
                end
            end
            scs_pkg::FSM_EXEC: begin
                n_state  = scs_pkg::FSM_FINISH;
                n_status = scs_pkg::STS_OK;
                unique case (i_stat.action)
                    scs_pkg::ACT_SET: begin
                        n_src = scs_pkg::SRC_SET;
                    end
                    scs_pkg::ACT_PUSH: begin
                        if (i_stat.full) begin
                            n_src    = scs_pkg::SRC_NONE;
                            n_status = scs_pkg::STS_OVERFLOW;
                        end else begin
                            o_cmd.push = 1'b1;
                            n_src      = scs_pkg::SRC_PUSH;
                        end
                    end
                    scs_pkg::ACT_POP: begin
                        if (i_stat.empty) begin
                            n_src    = scs_pkg::SRC_NONE;
                            n_status = scs_pkg::STS_UNDERFLOW;
                        end else begin
                            o_cmd.pop = 1'b1;
                            n_src     = scs_pkg::SRC_POP;
                        end
                    end
                    scs_pkg::ACT_FRAME: begin
                        n_src = scs_pkg::SRC_CLEAR;
                    end
                    default: begin
                        n_src = scs_pkg::SRC_NONE;
                    end
                endcase
            end
            scs_pkg::FSM_FINISH: begin
                // hold until the output register is free
                if (!r_out_valid || i_ready) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = scs_pkg::FSM_IDLE;
                end
            end
            default: begin
                n_state = scs_pkg::FSM_IDLE;
            end
        endcase
    end

    assign o_valid = r_out_valid;

endmodule

// ===== sv/scs_datapath.sv =====
// Datapath for the scissor clip stack: request capture, current rectangle,
// save stack memory, intersection and result register. Depends on scs_pkg.
`timescale 1ns / 1ps

module scs_datapath #(
    parameter int unsigned STACK_DEPTH = scs_pkg::STACK_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  scs_pkg::t_dp_cmd    i_cmd,
    output scs_pkg::t_dp_stat   o_stat,
    input  logic [1:0]          i_action,
    input  logic                i_enable_in,
    input  logic signed [15:0]  i_rect_x,
    input  logic signed [15:0]  i_rect_y,
    input  logic signed [15:0]  i_rect_w,
    input  logic signed [15:0]  i_rect_h,
    output logic                o_command_valid,
    output logic                o_scissor_on,
    output logic signed [15:0]  o_out_x,
    output logic signed [15:0]  o_out_y,
    output logic [14:0]         o_out_w,
    output logic [14:0]         o_out_h,
    output logic [1:0]          o_status
);

    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // captured request
    scs_pkg::t_action   r_in_action;
    logic               r_in_en;
    logic signed [15:0] r_in_x;
    logic signed [15:0] r_in_y;
    logic [14:0]        r_in_w;
    logic [14:0]        r_in_h;

    scs_pkg::t_rect     r_cur;
    logic [CW-1:0]      r_count;
    scs_pkg::t_rect     r_mem [STACK_DEPTH];
    scs_pkg::t_rect     r_rd_data;

    // intersection edges
    logic               r_isect;
    logic signed [15:0] r_l, r_b;
    logic signed [16:0] r_r, r_t;

    logic                  r_o_cmd_valid;
    scs_pkg::t_rect        r_o_rect;
    scs_pkg::t_status      r_o_status;

    logic signed [16:0] w_in_right, w_in_top, w_cur_right, w_cur_top;
    logic signed [15:0] w_l, w_b;
    logic signed [16:0] w_r, w_t;
    logic signed [17:0] w_dx, w_dy;
    logic [CW-1:0]      w_pop_cnt;
    scs_pkg::t_rect     w_set_rect, w_push_rect, n_cur;
    logic               w_cmd_valid;

    assign w_in_right  = {r_in_x[15], r_in_x} + $signed({2'b00, r_in_w});
    assign w_in_top    = {r_in_y[15], r_in_y} + $signed({2'b00, r_in_h});
    assign w_cur_right = {r_cur.left[15], r_cur.left} + $signed({2'b00, r_cur.width});
    assign w_cur_top   = {r_cur.bottom[15], r_cur.bottom} + $signed({2'b00, r_cur.height});

    assign w_l = (r_in_x > r_cur.left)   ? r_in_x : r_cur.left;
    assign w_b = (r_in_y > r_cur.bottom) ? r_in_y : r_cur.bottom;
    assign w_r = (w_in_right < w_cur_right) ? w_in_right : w_cur_right;
    assign w_t = (w_in_top < w_cur_top)     ? w_in_top   : w_cur_top;

    assign w_dx = {r_r[16], r_r} - {{2{r_l[15]}}, r_l};
    assign w_dy = {r_t[16], r_t} - {{2{r_b[15]}}, r_b};

    assign w_pop_cnt = r_count - CW'(1);

    always_comb begin
        w_set_rect.en     = r_in_en;
        w_set_rect.left   = r_in_x;
        w_set_rect.bottom = r_in_y;
        w_set_rect.width  = r_in_w;
        w_set_rect.height = r_in_h;

        w_push_rect.en = 1'b1;
        if (r_isect) begin
            w_push_rect.left   = r_l;
            w_push_rect.bottom = r_b;
            w_push_rect.width  = w_dx[17] ? 15'd0 : w_dx[14:0];
            w_push_rect.height = w_dy[17] ? 15'd0 : w_dy[14:0];
        end else begin
            w_push_rect.left   = r_in_x;
            w_push_rect.bottom = r_in_y;
            w_push_rect.width  = r_in_w;
            w_push_rect.height = r_in_h;
        end

        n_cur       = r_cur;
        w_cmd_valid = 1'b0;
        unique case (i_cmd.src)
            scs_pkg::SRC_SET: begin
                n_cur       = w_set_rect;
                w_cmd_valid = 1'b1;
            end
            scs_pkg::SRC_PUSH: begin
                n_cur       = w_push_rect;
                w_cmd_valid = 1'b1;
            end
            scs_pkg::SRC_POP: begin
                n_cur       = r_rd_data;
                w_cmd_valid = 1'b1;
            end
            scs_pkg::SRC_CLEAR: begin
                n_cur = '0;
            end
            default: begin
                n_cur = r_cur;
            end
        endcase
    end

    // control state: current rectangle and stack fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.push) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.pop) begin
                r_count <= w_pop_cnt;
            end else if (i_cmd.commit && i_cmd.src == scs_pkg::SRC_CLEAR) begin
                r_count <= '0;
            end
            if (i_cmd.commit) begin
                r_cur <= n_cur;
            end
        end
    end

    // stack memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_count[AW-1:0]] <= r_cur;
        end
        if (i_cmd.pop) begin
            r_rd_data <= r_mem[w_pop_cnt[AW-1:0]];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in_action <= scs_pkg::t_action'(i_action);
            r_in_en     <= i_enable_in;
            r_in_x      <= i_rect_x;
            r_in_y      <= i_rect_y;
            r_in_w      <= i_rect_w[15] ? 15'd0 : i_rect_w[14:0];
            r_in_h      <= i_rect_h[15] ? 15'd0 : i_rect_h[14:0];
        end
        if (i_cmd.push) begin
            r_isect <= r_cur.en;
            r_l     <= w_l;
            r_b     <= w_b;
            r_r     <= w_r;
            r_t     <= w_t;
        end
        if (i_cmd.commit) begin
            r_o_cmd_valid <= w_cmd_valid;
            r_o_rect      <= w_cmd_valid ? n_cur : '0;
            r_o_status    <= i_cmd.status;
        end
    end

    assign o_stat.action = r_in_action;
    assign o_stat.full   = (r_count == CW'(STACK_DEPTH));
    assign o_stat.empty  = (r_count == '0);

    assign o_command_valid = r_o_cmd_valid;
    assign o_scissor_on    = r_o_rect.en;
    assign o_out_x         = r_o_rect.left;
    assign o_out_y         = r_o_rect.bottom;
    assign o_out_w         = r_o_rect.width;
    assign o_out_h         = r_o_rect.height;
    assign o_status        = r_o_status;

endmodule

// ===== sv/scissor_clip_stack.sv =====
// Scissor clip stack: a new request is taken only after the previous one has
// committed. A request is captured in the idle state, executed in the exec
// state (stack memory write or read, edge compares for the clip intersection)
// and committed to the output register in the finish state; the single-port
// stack memory with its registered read sets that split. The next request is
// taken in the cycle after commit, even while the previous result still waits
// on o_valid. Results leave in request order, one per request. The stack holds
// up to STACK_DEPTH saved rectangles and needs no clearing pass after reset.
//
// Top level of the scissor clip stack; depends on scs_pkg, scs_ctrl and
// scs_datapath.
`timescale 1ns / 1ps

module scissor_clip_stack #(
    parameter int unsigned STACK_DEPTH = scs_pkg::STACK_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_action,
    input  logic               i_enable_in,
    input  logic signed [15:0] i_rect_x,
    input  logic signed [15:0] i_rect_y,
    input  logic signed [15:0] i_rect_w,
    input  logic signed [15:0] i_rect_h,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_command_valid,
    output logic               o_scissor_on,
    output logic signed [15:0] o_out_x,
    output logic signed [15:0] o_out_y,
    output logic [14:0]        o_out_w,
    output logic [14:0]        o_out_h,
    output logic [1:0]         o_status
);

    scs_pkg::t_dp_cmd  w_cmd;
    scs_pkg::t_dp_stat w_stat;

    scs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    scs_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_action        (i_action),
        .i_enable_in     (i_enable_in),
        .i_rect_x        (i_rect_x),
        .i_rect_y        (i_rect_y),
        .i_rect_w        (i_rect_w),
        .i_rect_h        (i_rect_h),
        .o_command_valid (o_command_valid),
        .o_scissor_on    (o_scissor_on),
        .o_out_x         (o_out_x),
        .o_out_y         (o_out_y),
        .o_out_w         (o_out_w),
        .o_out_h         (o_out_h),
        .o_status        (o_status)
    );

endmodule

// ===== sv/scs_checker.sv =====
// Port-level checks for the scissor clip stack, bound to the top level.
// Depends on scs_pkg for status codes.
`timescale 1ns / 1ps

module scs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic               o_command_valid,
    input logic               o_scissor_on,
    input logic signed [15:0] o_out_x,
    input logic signed [15:0] o_out_y,
    input logic [14:0]        o_out_w,
    input logic [14:0]        o_out_h,
    input logic [1:0]         o_status
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_command_valid) && $stable(o_status)
            && $stable(o_out_x) && $stable(o_out_y) && $stable(o_out_w) && $stable(o_out_h))
        else $error("result changed while stalled");

    // an error status never carries a command
    a_err_no_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != scs_pkg::STS_OK |-> !o_command_valid)
        else $error("command emitted with error status");

    // no command means all rectangle fields are zero
    a_no_cmd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_command_valid |-> !o_scissor_on && o_out_x == '0 && o_out_y == '0
            && o_out_w == '0 && o_out_h == '0)
        else $error("nonzero fields without command");

    // a request is taken only after the previous one has committed
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("request taken while busy");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind scissor_clip_stack scs_checker u_scs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_command_valid (o_command_valid),
    .o_scissor_on    (o_scissor_on),
    .o_out_x         (o_out_x),
    .o_out_y         (o_out_y),
    .o_out_w         (o_out_w),
    .o_out_h         (o_out_h),
    .o_status        (o_status)
);
